### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the run queue engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define MQAE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define MQAE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define MQAE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/mqae_pkg.sv
// ----------------------------------------------------------------------------
// mqae_pkg
// Types and constants of the multilevel run queue engine.
// ----------------------------------------------------------------------------
package mqae_pkg;

  localparam int PROC_W   = 6;
  localparam int LEVEL_W  = 3;
  localparam int STAMP_W  = 32;
  localparam int LIMIT_W  = 20;
  localparam int VALUE_W  = 7;
  localparam int QSEL_W   = 3;
  localparam int STATUS_W = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd64;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_LEN   = 2'd2,
    OP_SPLIT = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [STAMP_W-1:0] stamp;
    logic [PROC_W-1:0]  proc;
  } entry_t;

endpackage

### rtl/core/mqae_ram.sv
// ----------------------------------------------------------------------------
// mqae_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mqae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### rtl/core/multilevel_queue_aging_engine.sv
// ----------------------------------------------------------------------------
// multilevel_queue_aging_engine
// Run queues over a shared pool of linked entries: push, pop, length, split.
// ----------------------------------------------------------------------------
// Length and refused, empty or full requests answer from decode; pop reads the
// head entry; push writes the entry, first reading the free list once freed
// entries are reused; split walks the queue, one entry per RAM read.
// One request is in flight at a time; the next beat is taken in the cycle after
// the result is registered, even while that result waits on out_tready.
// Reset (rst_n low, synchronous) empties all queues and the pool.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multilevel_queue_aging_engine #(
  parameter int NUM_ENTRIES = 64,
  parameter int NUM_QUEUES  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // cfg: aging_limit [19:0]
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata,
  // in_tdata: queue_sel [2:0], target_queue [5:3], proc_id [11:6], now [43:12]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  // in_tuser: opcode [1:0]
  input  logic [1:0]  in_tuser,
  // out_tdata: value [6:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  // out_tuser: status [1:0]
  output logic [1:0]  out_tuser
);

  localparam int EW = $clog2(NUM_ENTRIES);
  localparam int CW = $clog2(NUM_ENTRIES + 1);
  localparam int QW = $clog2(NUM_QUEUES);
  localparam int DW = $bits(mqae_pkg::entry_t);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DECODE  = 8'b0000_0010,
    S_PUSH_FL = 8'b0000_0100,
    S_PUSH_WR = 8'b0000_1000,
    S_POP_RD  = 8'b0001_0000,
    S_SPL_RD  = 8'b0010_0000,
    S_SPL_FIX = 8'b0100_0000,
    S_RESP    = 8'b1000_0000
  } state_t;

  state_t                              state_r, state_nxt;
  mqae_pkg::opcode_t                   op_r, op_nxt;
  logic [mqae_pkg::QSEL_W-1:0]         src_r, src_nxt, dst_r, dst_nxt;
  logic [mqae_pkg::PROC_W-1:0]         pid_r, pid_nxt;
  logic [mqae_pkg::STAMP_W-1:0]        now_r, now_nxt;
  logic [mqae_pkg::LIMIT_W-1:0]        limit_r;
  logic [CW-1:0]                       fresh_r, fresh_nxt;
  logic [CW-1:0]                       fl_cnt_r, fl_cnt_nxt;
  logic [EW-1:0]                       fl_head_r, fl_head_nxt;
  logic [EW-1:0]                       qhead_r [NUM_QUEUES];
  logic [EW-1:0]                       qhead_nxt [NUM_QUEUES];
  logic [EW-1:0]                       qtail_r [NUM_QUEUES];
  logic [EW-1:0]                       qtail_nxt [NUM_QUEUES];
  logic [CW-1:0]                       qcnt_r [NUM_QUEUES];
  logic [CW-1:0]                       qcnt_nxt [NUM_QUEUES];
  logic [EW-1:0]                       alloc_r, alloc_nxt;
  logic [EW-1:0]                       cur_r, cur_nxt;
  logic [EW-1:0]                       first_r, first_nxt;
  logic [EW-1:0]                       last_r, last_nxt;
  logic [CW-1:0]                       moved_r, moved_nxt;
  logic [CW-1:0]                       rem_r, rem_nxt;
  logic [mqae_pkg::VALUE_W-1:0]        res_val_r, res_val_nxt;
  mqae_pkg::status_t                   res_st_r, res_st_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [mqae_pkg::VALUE_W-1:0]        out_val_r, out_val_nxt;
  mqae_pkg::status_t                   out_st_r, out_st_nxt;

  logic                                d_we, n_we;
  logic [EW-1:0]                       d_waddr, d_raddr, n_waddr, n_raddr;
  mqae_pkg::entry_t                    d_wdata, d_rdata;
  logic [DW-1:0]                       d_rdata_raw;
  logic [EW-1:0]                       n_wdata, n_rdata;

  logic [QW-1:0]                       src_q, dst_q, sel_q;
  logic                                src_bad, dst_bad, pool_full, aged;
  logic [EW-1:0]                       qh, qt;
  logic [CW-1:0]                       qc;
  logic [mqae_pkg::STAMP_W-1:0]        age;
  logic                                in_acc;

  mqae_ram #(.WIDTH(DW), .DEPTH(NUM_ENTRIES)) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata_raw)
  );

  mqae_ram #(.WIDTH(EW), .DEPTH(NUM_ENTRIES)) u_next_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  assign d_rdata = mqae_pkg::entry_t'(d_rdata_raw);

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_val_r};
  assign out_tuser  = out_st_r;

  assign src_q     = QW'(src_r);
  assign dst_q     = QW'(dst_r);
  assign src_bad   = (32'(src_r) >= 32'(NUM_QUEUES));
  assign dst_bad   = (32'(dst_r) >= 32'(NUM_QUEUES));
  assign sel_q     = (state_r == S_SPL_FIX) ? dst_q : src_q;
  assign qh        = qhead_r[sel_q];
  assign qt        = qtail_r[sel_q];
  assign qc        = qcnt_r[sel_q];
  assign pool_full = (fresh_r == CW'(NUM_ENTRIES)) && (fl_cnt_r == '0);
  assign age       = now_r - d_rdata.stamp;
  assign aged      = (age > 32'(limit_r));

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    pid_nxt       = pid_r;
    now_nxt       = now_r;
    fresh_nxt     = fresh_r;
    fl_cnt_nxt    = fl_cnt_r;
    fl_head_nxt   = fl_head_r;
    qhead_nxt     = qhead_r;
    qtail_nxt     = qtail_r;
    qcnt_nxt      = qcnt_r;
    alloc_nxt     = alloc_r;
    cur_nxt       = cur_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    moved_nxt     = moved_r;
    rem_nxt       = rem_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    d_we          = 1'b0;
    d_waddr       = cur_r;
    d_wdata       = d_rdata;
    d_raddr       = cur_r;
    n_we          = 1'b0;
    n_waddr       = cur_r;
    n_wdata       = cur_r;
    n_raddr       = cur_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = mqae_pkg::opcode_t'(in_tuser);
          src_nxt   = in_tdata[2:0];
          dst_nxt   = in_tdata[5:3];
          pid_nxt   = in_tdata[11:6];
          now_nxt   = in_tdata[43:12];
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        res_val_nxt = '0;
        res_st_nxt  = mqae_pkg::ST_OK;
        state_nxt   = S_RESP;
        if (src_bad) begin
          res_st_nxt = mqae_pkg::ST_BAD;
        end else begin
          unique case (op_r)
            mqae_pkg::OP_PUSH: begin
              if (pool_full) begin
                res_st_nxt = mqae_pkg::ST_FULL;
              end else if (fresh_r != CW'(NUM_ENTRIES)) begin
                alloc_nxt = fresh_r[EW-1:0];
                fresh_nxt = fresh_r + CW'(1);
                state_nxt = S_PUSH_WR;
              end else begin
                alloc_nxt = fl_head_r;
                n_raddr   = fl_head_r;
                state_nxt = S_PUSH_FL;
              end
            end
            mqae_pkg::OP_POP: begin
              if (qc == '0) begin
                res_st_nxt = mqae_pkg::ST_EMPTY;
              end else begin
                d_raddr   = qh;
                n_raddr   = qh;
                state_nxt = S_POP_RD;
              end
            end
            mqae_pkg::OP_LEN: begin
              res_val_nxt = mqae_pkg::VALUE_W'(qc);
            end
            mqae_pkg::OP_SPLIT: begin
              if (dst_bad || (dst_r == src_r)) begin
                res_st_nxt = mqae_pkg::ST_BAD;
              end else if (qc != '0) begin
                d_raddr   = qh;
                n_raddr   = qh;
                cur_nxt   = qh;
                first_nxt = qh;
                moved_nxt = '0;
                rem_nxt   = qc;
                state_nxt = S_SPL_RD;
              end
            end
            default: begin
              res_st_nxt = mqae_pkg::ST_BAD;
            end
          endcase
        end
      end

      S_PUSH_FL: begin
        fl_head_nxt = n_rdata;
        fl_cnt_nxt  = fl_cnt_r - CW'(1);
        state_nxt   = S_PUSH_WR;
      end

      S_PUSH_WR: begin
        d_we          = 1'b1;
        d_waddr       = alloc_r;
        d_wdata.level = src_r;
        d_wdata.stamp = now_r;
        d_wdata.proc  = pid_r;
        if (qc != '0) begin
          n_we    = 1'b1;
          n_waddr = qt;
          n_wdata = alloc_r;
        end else begin
          qhead_nxt[src_q] = alloc_r;
        end
        qtail_nxt[src_q] = alloc_r;
        qcnt_nxt[src_q]  = qc + CW'(1);
        res_val_nxt      = '0;
        res_st_nxt       = mqae_pkg::ST_OK;
        state_nxt        = S_RESP;
      end

      S_POP_RD: begin
        n_we            = 1'b1;
        n_waddr         = qh;
        n_wdata         = fl_head_r;
        fl_head_nxt     = qh;
        fl_cnt_nxt      = fl_cnt_r + CW'(1);
        qcnt_nxt[src_q] = qc - CW'(1);
        if (qc != CW'(1)) begin
          qhead_nxt[src_q] = n_rdata;
        end
        res_val_nxt = mqae_pkg::VALUE_W'(d_rdata.proc);
        res_st_nxt  = mqae_pkg::ST_OK;
        state_nxt   = S_RESP;
      end

      S_SPL_RD: begin
        if (aged) begin
          d_we          = 1'b1;
          d_waddr       = cur_r;
          d_wdata.stamp = now_r;
          d_wdata.level = (d_rdata.level != '0) ? d_rdata.level - 3'd1 : d_rdata.level;
          moved_nxt     = moved_r + CW'(1);
          rem_nxt       = rem_r - CW'(1);
          last_nxt      = cur_r;
          cur_nxt       = n_rdata;
          if (rem_r != CW'(1)) begin
            d_raddr = n_rdata;
            n_raddr = n_rdata;
          end else begin
            state_nxt = S_SPL_FIX;
          end
        end else begin
          state_nxt = S_SPL_FIX;
        end
      end

      S_SPL_FIX: begin
        res_st_nxt = mqae_pkg::ST_OK;
        if (moved_r == '0) begin
          res_val_nxt = '0;
        end else begin
          qcnt_nxt[src_q] = rem_r;
          if (rem_r != '0) begin
            qhead_nxt[src_q] = cur_r;
          end
          if (qc == '0) begin
            qhead_nxt[dst_q] = first_r;
          end else begin
            n_we    = 1'b1;
            n_waddr = qt;
            n_wdata = first_r;
          end
          qtail_nxt[dst_q] = last_r;
          qcnt_nxt[dst_q]  = qc + moved_r;
          res_val_nxt      = mqae_pkg::VALUE_W'(moved_r);
        end
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= mqae_pkg::LIMIT_RESET;
      fresh_r     <= '0;
      fl_cnt_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        qcnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      fresh_r     <= fresh_nxt;
      fl_cnt_r    <= fl_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      qcnt_r      <= qcnt_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    src_r     <= src_nxt;
    dst_r     <= dst_nxt;
    pid_r     <= pid_nxt;
    now_r     <= now_nxt;
    fl_head_r <= fl_head_nxt;
    qhead_r   <= qhead_nxt;
    qtail_r   <= qtail_nxt;
    alloc_r   <= alloc_nxt;
    cur_r     <= cur_nxt;
    first_r   <= first_nxt;
    last_r    <= last_nxt;
    moved_r   <= moved_nxt;
    rem_r     <= rem_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    out_val_r <= out_val_nxt;
    out_st_r  <= out_st_nxt;
  end

  `MQAE_ASSERT_ALWAYS(a_free_le_fresh, fl_cnt_r <= fresh_r, "free count exceeds issued entries")
  `MQAE_ASSERT_SAME(a_walk_has_work, state_r == S_SPL_RD, rem_r != '0, "empty split walk")
  `MQAE_ASSERT_SAME(a_out_from_resp, $rose(out_valid_r), $past(state_r == S_RESP), "stray beat")
  `MQAE_ASSERT_NEXT(a_accept_decodes, in_acc, state_r == S_DECODE, "accepted beat not decoded")

endmodule

### tb/tb_multilevel_queue_aging_engine.sv
// ----------------------------------------------------------------------------
// tb_multilevel_queue_aging_engine
// Drives push, pop, length and split requests into the run queue engine under
// several aging limits and handshake idling patterns. A scoreboard keeps its
// own copy of the queues and the entry pool, predicts value and status for
// every accepted request and compares them in order with the result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multilevel_queue_aging_engine;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 250;

  class run_queue_scoreboard;
    localparam int POOL_DEPTH  = 64;
    localparam int QUEUE_COUNT = 8;

    bit [mqae_pkg::LIMIT_W-1:0]  aging_limit;
    bit                          used[POOL_DEPTH];
    bit [5:0]                    link[POOL_DEPTH];
    bit [mqae_pkg::PROC_W-1:0]   pid_of[POOL_DEPTH];
    bit [mqae_pkg::STAMP_W-1:0]  stamp_of[POOL_DEPTH];
    bit [mqae_pkg::LEVEL_W-1:0]  level_of[POOL_DEPTH];
    bit [5:0]                    head[QUEUE_COUNT];
    bit [5:0]                    tail[QUEUE_COUNT];
    bit [mqae_pkg::VALUE_W-1:0]  count[QUEUE_COUNT];
    bit [mqae_pkg::VALUE_W-1:0]  exp_value[$];
    bit [mqae_pkg::STATUS_W-1:0] exp_status[$];
    int                          failures;

    function new();
      aging_limit = mqae_pkg::LIMIT_RESET;
      failures = 0;
      for (int i = 0; i < POOL_DEPTH; i++) used[i] = 1'b0;
      for (int i = 0; i < QUEUE_COUNT; i++) count[i] = '0;
    endfunction

    function int pending();
      return exp_value.size();
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void append_run(bit [2:0] dst, bit [5:0] first, bit [5:0] last,
                             bit [mqae_pkg::VALUE_W-1:0] n);
      if (count[dst] == 0) head[dst] = first;
      else link[tail[dst]] = first;
      tail[dst] = last;
      count[dst] = count[dst] + n;
    endfunction

    function void note_request(mqae_pkg::opcode_t op, bit [2:0] q, bit [2:0] tq,
                               bit [5:0] pid, bit [31:0] now);
      bit [mqae_pkg::VALUE_W-1:0] value;
      mqae_pkg::status_t          status;
      int                         slot;
      bit [5:0]                   first;
      bit [5:0]                   cur;
      bit [5:0]                   last;
      bit [mqae_pkg::VALUE_W-1:0] moved;
      bit [mqae_pkg::VALUE_W-1:0] left;
      bit [31:0]                  age;
      value = '0;
      status = mqae_pkg::ST_OK;
      case (op)
        mqae_pkg::OP_PUSH: begin
          slot = -1;
          for (int i = POOL_DEPTH - 1; i >= 0; i--) if (!used[i]) slot = i;
          if (slot < 0) status = mqae_pkg::ST_FULL;
          else begin
            used[slot] = 1'b1;
            pid_of[slot] = pid;
            stamp_of[slot] = now;
            level_of[slot] = q;
            link[slot] = '0;
            append_run(q, slot[5:0], slot[5:0], 1);
          end
        end
        mqae_pkg::OP_POP: begin
          if (count[q] == 0) status = mqae_pkg::ST_EMPTY;
          else begin
            first = head[q];
            used[first] = 1'b0;
            count[q] = count[q] - 1;
            if (count[q] != 0) head[q] = link[first];
            value = pid_of[first];
          end
        end
        mqae_pkg::OP_LEN: value = count[q];
        default: begin
          if (tq == q) status = mqae_pkg::ST_BAD;
          else if (count[q] != 0) begin
            first = head[q];
            cur = first;
            last = '0;
            left = count[q];
            moved = '0;
            while (left != 0) begin
              age = now - stamp_of[cur];
              if (age <= aging_limit) break;
              if (level_of[cur] != 0) level_of[cur] = level_of[cur] - 1;
              stamp_of[cur] = now;
              moved++;
              left--;
              last = cur;
              cur = link[cur];
            end
            if (moved != 0) begin
              count[q] = left;
              if (left != 0) head[q] = cur;
              link[last] = '0;
              append_run(tq, first, last, moved);
              value = moved;
            end
          end
        end
      endcase
      exp_value.push_back(value);
      exp_status.push_back(status);
    endfunction

    function void check_result(bit [mqae_pkg::VALUE_W-1:0] value,
                               bit [mqae_pkg::STATUS_W-1:0] status);
      bit [mqae_pkg::VALUE_W-1:0]  ev;
      bit [mqae_pkg::STATUS_W-1:0] es;
      if (exp_value.size() == 0) begin
        report($sformatf("unexpected beat value %0d status %0d", value, status));
        return;
      end
      ev = exp_value.pop_front();
      es = exp_status.pop_front();
      if (value != ev)
        report($sformatf("value expected %0d got %0d", ev, value));
      if (status != es)
        report($sformatf("status expected %0d got %0d", es, status));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [19:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;

  run_queue_scoreboard sb = new();

  int          send_idle_pct = 7;
  int          recv_idle_pct = 61;
  bit          stall_req = 1'b0;
  bit          stall_done = 1'b0;
  int          stall_left = 0;
  int          cycle_count = 0;
  bit [31:0]   tick = '0;

  multilevel_queue_aging_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** multilevel_queue_aging_engine: FAILED **");
      $finish;
    end
  end

  // Hold off the result side for a long stretch once requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_req && !stall_done) begin
      out_tready <= 1'b0;
      stall_left <= HOLD_CYCLES;
      stall_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata[6:0], out_tuser);
  end

  task automatic offer(mqae_pkg::opcode_t op, bit [2:0] q, bit [2:0] tq, bit [5:0] pid,
                       bit [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {4'd0, now, pid, tq, q};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, q, tq, pid, now);
  endtask

  task automatic write_limit(bit [mqae_pkg::LIMIT_W-1:0] lim);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.aging_limit = lim;
  endtask

  function automatic bit [2:0] pick_queue();
    return ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3));
  endfunction

  task automatic random_requests(int n, bit with_stall);
    int                r;
    int                lim;
    bit                filling;
    mqae_pkg::opcode_t op;
    bit [2:0]          q;
    bit [2:0]          tq;
    bit [31:0]         now;
    filling = 1'b1;
    for (int k = 0; k < n; k++) begin
      if (with_stall && k == 60) stall_req = 1'b1;
      if (k % 40 == 39) filling = $urandom_range(1);
      lim = sb.aging_limit;
      r = $urandom_range(99);
      if (r < 60) tick = tick + $urandom_range(0, lim / 8 + 1);
      else if (r < 95) tick = tick + $urandom_range(0, lim + 2);
      else tick = tick + $urandom_range(0, 4 * lim + 8);
      r = $urandom_range(99);
      if (filling)
        op = (r < 55) ? mqae_pkg::OP_PUSH : (r < 70) ? mqae_pkg::OP_POP :
             (r < 78) ? mqae_pkg::OP_LEN : mqae_pkg::OP_SPLIT;
      else
        op = (r < 20) ? mqae_pkg::OP_PUSH : (r < 60) ? mqae_pkg::OP_POP :
             (r < 70) ? mqae_pkg::OP_LEN : mqae_pkg::OP_SPLIT;
      q = pick_queue();
      tq = pick_queue();
      if (op == mqae_pkg::OP_SPLIT && $urandom_range(9) != 0 && tq == q)
        tq = q + 3'($urandom_range(1, 7));
      now = ($urandom_range(19) == 0) ? $urandom : tick;
      offer(op, q, tq, 6'($urandom_range(63)), now);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_limit(mqae_pkg::LIMIT_RESET);
    offer(mqae_pkg::OP_LEN,   3'd0, 3'd0, 6'd0,  32'd0);
    offer(mqae_pkg::OP_POP,   3'd3, 3'd0, 6'd0,  32'd0);
    offer(mqae_pkg::OP_SPLIT, 3'd2, 3'd5, 6'd0,  32'd0);
    offer(mqae_pkg::OP_SPLIT, 3'd4, 3'd4, 6'd0,  32'd0);
    offer(mqae_pkg::OP_PUSH,  3'd0, 3'd7, 6'd0,  32'h0000_0000);
    offer(mqae_pkg::OP_PUSH,  3'd0, 3'd0, 6'd63, 32'hFFFF_FFFF);
    offer(mqae_pkg::OP_PUSH,  3'd7, 3'd0, 6'd42, 32'hFFFF_FFF0);
    offer(mqae_pkg::OP_SPLIT, 3'd0, 3'd1, 6'd0,  32'd10);
    offer(mqae_pkg::OP_SPLIT, 3'd7, 3'd0, 6'd0,  32'h0000_0100);
    offer(mqae_pkg::OP_SPLIT, 3'd0, 3'd1, 6'd0,  32'h0000_0100);
    offer(mqae_pkg::OP_LEN,   3'd1, 3'd0, 6'd0,  32'h0000_0100);
    offer(mqae_pkg::OP_LEN,   3'd0, 3'd0, 6'd0,  32'h0000_0100);
    offer(mqae_pkg::OP_POP,   3'd1, 3'd0, 6'd0,  32'h0000_0100);
    offer(mqae_pkg::OP_POP,   3'd1, 3'd0, 6'd0,  32'h0000_0100);
    offer(mqae_pkg::OP_POP,   3'd1, 3'd0, 6'd0,  32'h0000_0100);
    offer(mqae_pkg::OP_POP,   3'd0, 3'd0, 6'd0,  32'h0000_0100);
    offer(mqae_pkg::OP_PUSH,  3'd5, 3'd0, 6'd21, 32'd5);
    offer(mqae_pkg::OP_PUSH,  3'd5, 3'd0, 6'd22, 32'd6);
    offer(mqae_pkg::OP_SPLIT, 3'd5, 3'd6, 6'd0,  32'd70);
    offer(mqae_pkg::OP_SPLIT, 3'd5, 3'd7, 6'd0,  32'd71);
    offer(mqae_pkg::OP_POP,   3'd6, 3'd0, 6'd0,  32'd71);
    offer(mqae_pkg::OP_POP,   3'd7, 3'd0, 6'd0,  32'd71);
    offer(mqae_pkg::OP_LEN,   3'd7, 3'd0, 6'd0,  32'd71);
    tick = 32'h0000_0200;

    write_limit(20'd0);
    random_requests(RANDOM_ITEMS, 1'b1);

    send_idle_pct = 61;
    recv_idle_pct = 7;
    write_limit(20'hF_FFFF);
    random_requests(RANDOM_ITEMS, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(20'($urandom_range(1, 400)));
    random_requests(RANDOM_ITEMS, 1'b0);

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("** multilevel_queue_aging_engine: PASSED **");
    else
      $display("** multilevel_queue_aging_engine: FAILED **");
    $finish;
  end

endmodule
